// File: hw/rtl/rtp_header_parser_macros.svh
// Assertion macros shared by the RTP header parser modules.
// Expects clk and rst_n in the scope of each use.
`ifndef RTP_HEADER_PARSER_MACROS_SVH
`define RTP_HEADER_PARSER_MACROS_SVH

// Checked on every clock edge once reset is released.
`define RHP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define RHP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/rhp_pkg.sv
// Types and constants for the RTP header parser.
// No dependencies; used by rhp_track, rhp_check and rtp_header_parser.
package rhp_pkg;

    localparam int RHP_BYTE_W         = 8;
    localparam int RHP_LEN_W          = 12;
    localparam int RHP_EXT_W          = 16;
    // header length: 12 + 4*15 + 4 + 4*65535 fits in 19 bits
    localparam int RHP_HDR_W          = 19;
    localparam int RHP_FIXED_HDR_BYTES = 12;
    localparam int RHP_EXT_HDR_BYTES   = 4;
    localparam int RHP_CC_W           = 4;

    localparam int RHP_MARKER_BIT     = 7;
    localparam int RHP_PAD_BIT        = 5;
    localparam int RHP_EXT_BIT        = 4;
    localparam logic [1:0] RHP_VERSION = 2'd2;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_SHORT       = 4'd1,
        ST_VERSION     = 4'd2,
        ST_CSRC_CUT    = 4'd3,
        ST_EXT_HDR_CUT = 4'd4,
        ST_EXT_CUT     = 4'd5,
        ST_PADDING     = 4'd6,
        ST_EMPTY       = 4'd7,
        ST_TOO_LONG    = 4'd8
    } status_t;

    typedef struct packed {
        logic [RHP_BYTE_W-1:0] data_byte;
        logic                  last;
    } pkt_word_t;

    typedef struct packed {
        status_t              status;
        logic [RHP_LEN_W-1:0] payload_offset;
        logic [RHP_LEN_W-1:0] payload_len;
        logic                 marker;
    } res_word_t;

    // per-packet header state handed from tracker to checker
    typedef struct packed {
        logic [RHP_BYTE_W-1:0] first_byte;
        logic                  marker;
        logic [RHP_EXT_W-1:0]  ext_words;
        logic                  overflowed;
        logic [RHP_BYTE_W-1:0] pad_count;
    } snap_t;

endpackage

// File: hw/rtl/rhp_track.sv
// Byte tracker: counts packet bytes, captures header fields, snapshots them on the last byte.
// Depends on rhp_pkg and rtp_header_parser_macros.svh.
`include "rtp_header_parser_macros.svh"

module rhp_track #(
    parameter int MAX_PACKET_BYTES = 2048,
    parameter int CW = $clog2(MAX_PACKET_BYTES + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pkt_valid,
    output logic               pkt_ready,
    input  rhp_pkg::pkt_word_t pkt,
    output logic               snap_valid,
    input  logic               snap_ready,
    output rhp_pkg::snap_t     snap,
    output logic [CW-1:0]      snap_size
);

    localparam int HSW  = 7;
    localparam int CMPW = (CW > HSW) ? CW : HSW;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PACKET_BYTES);

    logic [CW-1:0]                   byte_count_reg, byte_count_next;
    logic [rhp_pkg::RHP_BYTE_W-1:0]  first_byte_reg, first_byte_next;
    logic                            marker_reg, marker_next;
    logic [rhp_pkg::RHP_EXT_W-1:0]   ext_words_reg, ext_words_next;
    logic                            overflowed_reg, overflowed_next;
    logic                            snap_valid_reg;
    rhp_pkg::snap_t                  snap_reg;
    logic [CW-1:0]                   snap_size_reg;

    logic            accept;
    logic            in_range;
    logic [HSW-1:0]  hs;
    logic [CMPW-1:0] pos_x;
    logic [CMPW-1:0] ext_hi_pos;
    logic [CMPW-1:0] ext_lo_pos;

    assign pkt_ready = !snap_valid_reg || snap_ready;
    assign accept    = pkt_valid && pkt_ready;
    assign in_range  = byte_count_reg < MAX_CNT;

    assign hs = HSW'(rhp_pkg::RHP_FIXED_HDR_BYTES)
              + {1'b0, first_byte_reg[rhp_pkg::RHP_CC_W-1:0], 2'b00};
    assign pos_x      = CMPW'(byte_count_reg);
    assign ext_hi_pos = CMPW'(hs) + CMPW'(2);
    assign ext_lo_pos = CMPW'(hs) + CMPW'(3);

    always_comb
    begin
        byte_count_next = byte_count_reg;
        first_byte_next = first_byte_reg;
        marker_next     = marker_reg;
        ext_words_next  = ext_words_reg;
        overflowed_next = overflowed_reg;
        if (!in_range)
        begin
            overflowed_next = 1'b1;
        end
        else
        begin
            if (byte_count_reg == CW'(0))
            begin
                first_byte_next = pkt.data_byte;
            end
            if (byte_count_reg == CW'(1))
            begin
                marker_next = pkt.data_byte[rhp_pkg::RHP_MARKER_BIT];
            end
            if (byte_count_reg >= CW'(2))
            begin
                if (pos_x == ext_hi_pos)
                begin
                    ext_words_next = {pkt.data_byte, ext_words_reg[7:0]};
                end
                else if (pos_x == ext_lo_pos)
                begin
                    ext_words_next = {ext_words_reg[15:8], pkt.data_byte};
                end
            end
            byte_count_next = byte_count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            first_byte_reg <= '0;
            marker_reg     <= 1'b0;
            ext_words_reg  <= '0;
            overflowed_reg <= 1'b0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept && pkt.last)
            begin
                byte_count_reg <= '0;
                first_byte_reg <= '0;
                marker_reg     <= 1'b0;
                ext_words_reg  <= '0;
                overflowed_reg <= 1'b0;
                snap_valid_reg <= 1'b1;
            end
            else
            begin
                if (accept)
                begin
                    byte_count_reg <= byte_count_next;
                    first_byte_reg <= first_byte_next;
                    marker_reg     <= marker_next;
                    ext_words_reg  <= ext_words_next;
                    overflowed_reg <= overflowed_next;
                end
                if (snap_ready)
                begin
                    snap_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && pkt.last)
        begin
            snap_reg.first_byte <= first_byte_next;
            snap_reg.marker     <= marker_next;
            snap_reg.ext_words  <= ext_words_next;
            snap_reg.overflowed <= overflowed_next;
            snap_reg.pad_count  <= pkt.data_byte;
            snap_size_reg       <= byte_count_next;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;
    assign snap_size  = snap_size_reg;

    `RHP_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !snap_valid_reg, "snapshot valid out of reset")
    `RHP_ASSERT(a_count_bound, byte_count_reg <= MAX_CNT, "byte count past bound")
    `RHP_ASSERT(a_ovf_saturated, overflowed_reg |-> byte_count_reg == MAX_CNT,
                "overflow without saturated count")
    `RHP_ASSERT(a_clear_after_last, accept && pkt.last |=> byte_count_reg == '0 && !overflowed_reg,
                "packet state not cleared after last word")

endmodule

// File: hw/rtl/rhp_check.sv
// Header checker: derives status, payload offset and length from a packet snapshot,
// into the result register.
// Depends on rhp_pkg and rtp_header_parser_macros.svh.
`include "rtp_header_parser_macros.svh"

module rhp_check #(
    parameter int MAX_PACKET_BYTES = 2048,
    parameter int CW = $clog2(MAX_PACKET_BYTES + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               snap_valid,
    output logic               snap_ready,
    input  rhp_pkg::snap_t     snap,
    input  logic [CW-1:0]      snap_size,
    output logic               res_valid,
    input  logic               res_ready,
    output rhp_pkg::res_word_t res
);

    localparam int HW = rhp_pkg::RHP_HDR_W;

    logic               res_valid_reg;
    rhp_pkg::res_word_t res_reg, res_next;

    logic [HW-1:0] size_w;
    logic [HW-1:0] hs_base;
    logic [HW-1:0] hs_hdr;
    logic [HW-1:0] hs_ext;
    logic [HW-1:0] hs_full;
    logic [HW:0]   payload_diff;
    logic [HW:0]   net_diff;
    logic [HW-1:0] payload_net;
    logic          ext_flag;
    logic          pad_flag;
    rhp_pkg::status_t status;

    assign snap_ready = !res_valid_reg || res_ready;

    assign ext_flag = snap.first_byte[rhp_pkg::RHP_EXT_BIT];
    assign pad_flag = snap.first_byte[rhp_pkg::RHP_PAD_BIT];
    assign size_w   = HW'(snap_size);
    assign hs_base  = HW'(rhp_pkg::RHP_FIXED_HDR_BYTES)
                    + HW'({snap.first_byte[rhp_pkg::RHP_CC_W-1:0], 2'b00});
    assign hs_hdr   = hs_base + HW'(rhp_pkg::RHP_EXT_HDR_BYTES);
    assign hs_ext   = hs_hdr + HW'({snap.ext_words, 2'b00});
    assign hs_full  = ext_flag ? hs_ext : hs_base;

    // top bit of each difference is the borrow
    assign payload_diff = {1'b0, size_w} - {1'b0, hs_full};
    assign net_diff     = {1'b0, payload_diff[HW-1:0]} - (HW+1)'(snap.pad_count);
    assign payload_net  = pad_flag ? net_diff[HW-1:0] : payload_diff[HW-1:0];

    always_comb
    begin
        priority if (snap.overflowed)
        begin
            status = rhp_pkg::ST_TOO_LONG;
        end
        else if (size_w < HW'(rhp_pkg::RHP_FIXED_HDR_BYTES))
        begin
            status = rhp_pkg::ST_SHORT;
        end
        else if (snap.first_byte[7:6] != rhp_pkg::RHP_VERSION)
        begin
            status = rhp_pkg::ST_VERSION;
        end
        else if (size_w < hs_base)
        begin
            status = rhp_pkg::ST_CSRC_CUT;
        end
        else if (ext_flag && size_w < hs_hdr)
        begin
            status = rhp_pkg::ST_EXT_HDR_CUT;
        end
        else if (payload_diff[HW])
        begin
            status = rhp_pkg::ST_EXT_CUT;
        end
        else if (pad_flag && (snap.pad_count == '0 || net_diff[HW]))
        begin
            status = rhp_pkg::ST_PADDING;
        end
        else if (payload_net == '0)
        begin
            status = rhp_pkg::ST_EMPTY;
        end
        else
        begin
            status = rhp_pkg::ST_OK;
        end
    end

    always_comb
    begin
        res_next.status         = status;
        res_next.payload_offset = '0;
        res_next.payload_len    = '0;
        res_next.marker         = snap.marker;
        if (status == rhp_pkg::ST_OK)
        begin
            res_next.payload_offset = hs_full[rhp_pkg::RHP_LEN_W-1:0];
            res_next.payload_len    = payload_net[rhp_pkg::RHP_LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (snap_ready)
        begin
            res_valid_reg <= snap_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_valid && snap_ready)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `RHP_ASSERT(a_err_zero_fields,
                res_valid_reg && res_reg.status != rhp_pkg::ST_OK |->
                res_reg.payload_offset == '0 && res_reg.payload_len == '0,
                "error word carries payload fields")
    `RHP_ASSERT(a_ok_offset_min,
                res_valid_reg && res_reg.status == rhp_pkg::ST_OK |->
                res_reg.payload_offset >= rhp_pkg::RHP_LEN_W'(rhp_pkg::RHP_FIXED_HDR_BYTES)
                || MAX_PACKET_BYTES > 4095,
                "ok word with offset inside fixed header")
    `RHP_ASSERT(a_snap_to_result, snap_valid && snap_ready |=> res_valid_reg,
                "taken snapshot did not reach result register")

endmodule

// File: hw/rtl/rtp_header_parser.sv
// RTP header parser top level: byte tracker followed by header checker.
// Depends on rhp_pkg, rhp_track, rhp_check.
//
// Usage:
//   pkt channel (pkt_valid/pkt_ready/pkt): one packet byte per word, pkt.last
//   set on the final byte. res channel (res_valid/res_ready/res): one word per
//   packet with status, payload_offset, payload_len and marker.
//   Throughput: one byte word per cycle while res_ready is high, packets back to back with no gap.
//   Result path: the edge that takes the last byte loads the snapshot
//   register; the checker logic then loads the result word into the result
//   register, where it is valid.
//   Stall: when res_ready is low, the result register holds; the snapshot
//   register takes one more packet end, after which pkt_ready drops for every
//   byte, last or not, until the result word is taken.
//   Reset: rst_n clears the byte count, header capture and both valid flags;
//   the block takes words in the first cycle after reset.
//   Packets longer than MAX_PACKET_BYTES report too long; offset and length are
//   12-bit fields.
module rtp_header_parser #(
    parameter int MAX_PACKET_BYTES = 2048
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pkt_valid,
    output logic               pkt_ready,
    input  rhp_pkg::pkt_word_t pkt,
    output logic               res_valid,
    input  logic               res_ready,
    output rhp_pkg::res_word_t res
);

    localparam int CW = $clog2(MAX_PACKET_BYTES + 1);

    logic           snap_valid;
    logic           snap_ready;
    rhp_pkg::snap_t snap;
    logic [CW-1:0]  snap_size;

    rhp_track #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
        .CW               (CW)
    ) u_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .pkt_valid  (pkt_valid),
        .pkt_ready  (pkt_ready),
        .pkt        (pkt),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap),
        .snap_size  (snap_size)
    );

    rhp_check #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
        .CW               (CW)
    ) u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap),
        .snap_size  (snap_size),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

endmodule
